[hw/rtl/nfa_pkg.sv]
package nfa_pkg;

	localparam int MAX_IDS_DEF = 256;

	// used map row geometry
	localparam int ROW_W  = 32;
	localparam int ROW_LG = 5;

	localparam logic [8:0] POOL_RST   = 9'd256;
	localparam logic [6:0] OPT_PERIOD = 7'd100;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic       capture;
		logic       load_hint;
		logic       mod_start;
		logic       mod_step;
		logic       load_rem;
		logic       load_opt;
		logic       scan_run;
		logic       grant;
		logic       opt_set;
		logic       rd_id;
		logic       free_commit;
		logic       clear;
		logic       set_status;
		logic [1:0] status;
		logic       publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       hint_ok;
		logic       id_ok;
		logic       mod_done;
		logic       found;
		logic       last;
		logic       opt_due;
		logic       free_hit;
	} dp_sts_t;

endpackage

[hw/rtl/nfa_ctrl.sv]
module nfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  nfa_pkg::dp_sts_t   sts,
	output nfa_pkg::ctrl_cmd_t cmd
);
	import nfa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MOD,
		S_SCAN,
		S_OPT_LOAD,
		S_OPT_SCAN,
		S_FREE_CHK,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.cmd)
					CMD_ALLOC: begin
						if (sts.hint_ok) begin
							cmd.load_hint = 1'b1;
							state_nx      = S_SCAN;
						end else begin
							cmd.mod_start = 1'b1;
							state_nx      = S_MOD;
						end
					end
					CMD_FREE: begin
						if (sts.id_ok) begin
							cmd.rd_id = 1'b1;
							state_nx  = S_FREE_CHK;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_BAD;
							state_nx       = S_DONE;
						end
					end
					CMD_CLEAR: begin
						cmd.clear = 1'b1;
						state_nx  = S_DONE;
					end
					default: state_nx = S_DONE;
				endcase
			end
			S_MOD: begin
				if (sts.mod_done) begin
					cmd.load_rem = 1'b1;
					state_nx     = S_SCAN;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.found) begin
					cmd.grant = 1'b1;
					state_nx  = sts.opt_due ? S_OPT_LOAD : S_DONE;
				end else if (sts.last) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_FULL;
					state_nx       = S_DONE;
				end
			end
			S_OPT_LOAD: begin
				cmd.load_opt = 1'b1;
				state_nx     = S_OPT_SCAN;
			end
			S_OPT_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.found) begin
					cmd.opt_set = 1'b1;
					state_nx    = S_DONE;
				end else if (sts.last) begin
					state_nx = S_DONE;
				end
			end
			S_FREE_CHK: begin
				cmd.free_commit = 1'b1;
				if (!sts.free_hit) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_BAD;
				end
				state_nx = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_nx    = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/nfa_datapath.sv]
module nfa_datapath #(
	parameter int MAX_IDS = nfa_pkg::MAX_IDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [8:0]          cfg_wdata,
	input  logic [1:0]          command,
	input  logic [7:0]          free_id,
	input  nfa_pkg::ctrl_cmd_t  cmd,
	output nfa_pkg::dp_sts_t    sts,
	output logic [7:0]          granted_id,
	output logic [1:0]          status,
	output logic [8:0]          ids_in_use,
	output logic signed [8:0]   highest_used
);
	import nfa_pkg::*;

	localparam int IDX_W  = $clog2(MAX_IDS);
	localparam int SZ_W   = $clog2(MAX_IDS + 1);
	localparam int NROWS  = (MAX_IDS + ROW_W - 1) / ROW_W;
	localparam int RA_W   = (NROWS > 1) ? $clog2(NROWS) : 1;
	localparam int MOD_CW = $clog2(IDX_W + 1);

	function automatic logic [ROW_W-1:0] lt_mask(input logic [31:0] lim,
	                                             input logic [31:0] row);
		logic [31:0] lr;
		logic [31:0] lb;
		lr = lim >> ROW_LG;
		lb = lim & 32'(ROW_W - 1);
		if (row < lr) begin
			lt_mask = '1;
		end else if (row == lr) begin
			lt_mask = ROW_W'(((ROW_W + 1)'(1) << lb) - (ROW_W + 1)'(1));
		end else begin
			lt_mask = '0;
		end
	endfunction

	// configuration and captured word
	logic [8:0]             pool_size_q;
	logic [SZ_W-1:0]        size_q;
	logic [1:0]             cmd_q;
	logic [7:0]             id_q;

	// allocator state
	logic [ROW_W-1:0]       map_mem [NROWS];
	logic [NROWS-1:0]       row_valid_q;
	logic [IDX_W-1:0]       hint_q;
	logic [SZ_W-1:0]        count_q;
	logic signed [IDX_W:0]  mark_q;
	logic [6:0]             gcnt_q;

	// scan sequencing
	logic [RA_W-1:0]        row_q;
	logic                   pass_q;
	logic [IDX_W-1:0]       start_q;
	logic [RA_W-1:0]        stop_row_q;
	logic [RA_W-1:0]        last_row_q;

	// registered map read
	logic [ROW_W-1:0]       rdata_s1;
	logic                   rvalid_s1;
	logic [RA_W-1:0]        rrow_s1;
	logic                   rpass_s1;
	logic                   reval_s1;

	// remainder unit
	logic [SZ_W:0]          rem_q;
	logic [IDX_W-1:0]       div_q;
	logic [MOD_CW-1:0]      mcnt_q;

	// result staging and output word
	logic [IDX_W-1:0]       res_gid_q;
	logic [1:0]             res_st_q;
	logic [7:0]             granted_id_q;
	logic [1:0]             status_q;
	logic [8:0]             ids_q;
	logic [8:0]             high_q;

	logic [31:0]            act32;
	logic [SZ_W-1:0]        act_size;
	logic [IDX_W-1:0]       ld_start;
	logic [RA_W-1:0]        rd_addr;
	logic                   issue;
	logic [ROW_W-1:0]       base;
	logic [ROW_W-1:0]       cand;
	logic [ROW_LG-1:0]      fbit;
	logic                   found;
	logic [IDX_W-1:0]       found_pos;
	logic [IDX_W-1:0]       hint_nx;
	logic [6:0]             gcnt_nx;
	logic                   opt_due;
	logic [IDX_W-1:0]       id_idx;
	logic [RA_W-1:0]        id_row;
	logic [ROW_LG-1:0]      id_bit;
	logic                   free_hit;
	logic [SZ_W:0]          trial;
	logic                   wr_en;
	logic [RA_W-1:0]        wr_row;
	logic [ROW_W-1:0]       wr_data;

	always_comb begin
		act32 = 32'(pool_size_q);
		if (act32 == 32'd0) begin
			act32 = 32'd1;
		end
		if (act32 > 32'(MAX_IDS)) begin
			act32 = 32'(MAX_IDS);
		end
	end
	assign act_size = SZ_W'(act32);

	assign id_idx   = IDX_W'(32'(id_q));
	assign id_row   = RA_W'(32'(id_q) >> ROW_LG);
	assign id_bit   = id_q[ROW_LG-1:0];
	assign free_hit = rvalid_s1 & rdata_s1[id_bit];

	assign ld_start = cmd.load_rem ? IDX_W'(rem_q) : hint_q;
	assign issue    = cmd.scan_run | cmd.rd_id;
	assign rd_addr  = cmd.rd_id ? id_row : row_q;

	// candidate free bits of the row under evaluation
	always_comb begin
		base = rvalid_s1 ? rdata_s1 : '0;
		cand = ~base & lt_mask(32'(size_q), 32'(rrow_s1));
		if (rpass_s1) begin
			cand = cand & lt_mask(32'(start_q), 32'(rrow_s1));
		end else begin
			cand = cand & ~lt_mask(32'(start_q), 32'(rrow_s1));
		end
		fbit = '0;
		for (int b = ROW_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				fbit = ROW_LG'(b);
			end
		end
	end

	assign found     = reval_s1 & (|cand);
	assign found_pos = IDX_W'((32'(rrow_s1) << ROW_LG) | 32'(fbit));
	assign hint_nx   = ((32'(found_pos) + 32'd1) == 32'(size_q)) ? '0 :
	                   IDX_W'(32'(found_pos) + 32'd1);
	assign gcnt_nx   = gcnt_q + 7'd1;
	assign opt_due   = (gcnt_nx == OPT_PERIOD);
	assign trial     = {rem_q[SZ_W-1:0], div_q[IDX_W-1]};

	always_comb begin
		wr_en   = 1'b0;
		wr_row  = rrow_s1;
		wr_data = base | (ROW_W'(1) << fbit);
		if (cmd.grant) begin
			wr_en = 1'b1;
		end else if (cmd.free_commit && free_hit) begin
			wr_en   = 1'b1;
			wr_row  = id_row;
			wr_data = rdata_s1 & ~(ROW_W'(1) << id_bit);
		end
	end

	always_comb begin
		sts          = '0;
		sts.cmd      = cmd_q;
		sts.hint_ok  = (SZ_W'(hint_q) < size_q);
		sts.id_ok    = (32'(id_q) < 32'(size_q));
		sts.mod_done = (mcnt_q == '0);
		sts.found    = found;
		sts.last     = reval_s1 & rpass_s1 & (rrow_s1 == stop_row_q);
		sts.opt_due  = opt_due;
		sts.free_hit = free_hit;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1  <= map_mem[rd_addr];
			rvalid_s1 <= row_valid_q[rd_addr];
			rrow_s1   <= rd_addr;
			rpass_s1  <= pass_q;
		end
		if (wr_en) begin
			map_mem[wr_row] <= wr_data;
		end
		if (cmd.capture) begin
			cmd_q  <= command;
			id_q   <= free_id;
			size_q <= act_size;
		end
		if (cmd.publish) begin
			granted_id_q <= 8'(32'(res_gid_q));
			status_q     <= res_st_q;
			ids_q        <= 9'(32'(count_q));
			high_q       <= 9'(32'(mark_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_RST;
			row_valid_q <= '0;
			hint_q      <= '0;
			count_q     <= '0;
			mark_q      <= '1;
			gcnt_q      <= '0;
			row_q       <= '0;
			pass_q      <= 1'b0;
			start_q     <= '0;
			stop_row_q  <= '0;
			last_row_q  <= '0;
			reval_s1    <= 1'b0;
			rem_q       <= '0;
			div_q       <= '0;
			mcnt_q      <= '0;
			res_gid_q   <= '0;
			res_st_q    <= ST_OK;
		end else begin
			reval_s1 <= cmd.scan_run;
			if (cfg_we) begin
				pool_size_q <= cfg_wdata;
			end
			if (cmd.capture) begin
				res_gid_q <= '0;
				res_st_q  <= ST_OK;
			end
			if (cmd.set_status) begin
				res_st_q <= cmd.status;
			end
			if (cmd.mod_start) begin
				rem_q  <= '0;
				div_q  <= hint_q;
				mcnt_q <= MOD_CW'(IDX_W);
			end
			if (cmd.mod_step) begin
				rem_q  <= (trial >= (SZ_W + 1)'(size_q)) ?
				          trial - (SZ_W + 1)'(size_q) : trial;
				div_q  <= div_q << 1;
				mcnt_q <= mcnt_q - MOD_CW'(1);
			end
			if (cmd.load_hint || cmd.load_rem) begin
				start_q    <= ld_start;
				row_q      <= RA_W'(32'(ld_start) >> ROW_LG);
				stop_row_q <= RA_W'(32'(ld_start) >> ROW_LG);
				pass_q     <= 1'b0;
				last_row_q <= RA_W'((32'(size_q) - 32'd1) >> ROW_LG);
			end
			if (cmd.load_opt) begin
				start_q    <= hint_q;
				row_q      <= '0;
				stop_row_q <= RA_W'(32'(hint_q) >> ROW_LG);
				pass_q     <= 1'b1;
			end
			if (cmd.scan_run) begin
				if (!pass_q && (row_q == last_row_q)) begin
					row_q  <= '0;
					pass_q <= 1'b1;
				end else if (!(pass_q && (row_q == stop_row_q))) begin
					row_q <= row_q + RA_W'(1);
				end
			end
			if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			if (cmd.grant) begin
				res_gid_q <= found_pos;
				hint_q    <= hint_nx;
				count_q   <= count_q + SZ_W'(1);
				gcnt_q    <= opt_due ? '0 : gcnt_nx;
				if ($signed({1'b0, found_pos}) > mark_q) begin
					mark_q <= $signed({1'b0, found_pos});
				end
			end
			if (cmd.opt_set) begin
				hint_q <= found_pos;
			end
			if (cmd.free_commit && free_hit) begin
				count_q <= count_q - SZ_W'(1);
				if (id_idx < hint_q) begin
					hint_q <= id_idx;
				end
			end
			if (cmd.clear) begin
				row_valid_q <= '0;
				hint_q      <= '0;
				count_q     <= '0;
				mark_q      <= '1;
				gcnt_q      <= '0;
			end
		end
	end

	assign granted_id   = granted_id_q;
	assign status       = status_q;
	assign ids_in_use   = ids_q;
	assign highest_used = $signed(high_q);

endmodule

[hw/rtl/next_fit_id_allocator_unit.sv]
// Next-fit ID allocator. One command word is taken at a time and answered with
// one result word; the result register frees the input side while a result
// waits. Allocate examines the 32-bit used-map rows, at most ceil(pool/32)+1 of
// them, since the map has a single read port and is read one row per cycle;
// a bit-serial remainder runs first when the hint lies beyond a shrunk pool,
// and every 100th grant adds a second scan from row 0.
module next_fit_id_allocator_unit #(
	parameter int MAX_IDS = nfa_pkg::MAX_IDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [8:0]        pool_size,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	input  logic [7:0]        free_id,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        granted_id,
	output logic [1:0]        status,
	output logic [8:0]        ids_in_use,
	output logic signed [8:0] highest_used
);
	import nfa_pkg::*;

	ctrl_cmd_t ctl;
	dp_sts_t   dps;

	assign cfg_ready = 1'b1;

	nfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (dps),
		.cmd       (ctl)
	);

	nfa_datapath #(
		.MAX_IDS (MAX_IDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_wdata    (pool_size),
		.command      (command),
		.free_id      (free_id),
		.cmd          (ctl),
		.sts          (dps),
		.granted_id   (granted_id),
		.status       (status),
		.ids_in_use   (ids_in_use),
		.highest_used (highest_used)
	);

endmodule

[hw/rtl/nfa_checker.sv]
module nfa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [7:0]        granted_id,
	input logic [1:0]        status,
	input logic [8:0]        ids_in_use,
	input logic signed [8:0] highest_used
);
	import nfa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted_id) && $stable(status)
		&& $stable(ids_in_use) && $stable(highest_used))
		else $error("result word changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while one is in flight");

	a_full_gid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_BAD) |-> granted_id == 8'd0)
		else $error("nonzero id on a failed command");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> ids_in_use != 9'd0 && highest_used != -9'sd1)
		else $error("pool reported full with nothing allocated");

endmodule

bind next_fit_id_allocator_unit nfa_checker u_nfa_checker (.*);
